// ===== sv/e2q_pkg.sv =====
// Shared types, constants and helper functions for the Euler-to-quaternion block.
// No dependencies; every other file depends on this package.
package e2q_pkg;

  localparam int AngleW  = 16;
  localparam int OrderW  = 3;
  localparam int QuatW   = 16;
  localparam int ZW      = 20;   // half angle, Q.16
  localparam int XyW     = 32;   // CORDIC x/y, 30 fraction bits
  localparam int ScW     = 22;   // sine/cosine, Q.20
  localparam int PairW   = 2 * ScW;
  localparam int TripW   = 3 * ScW;
  localparam int Steps   = 16;
  localparam int LaneLat = Steps + 2;
  localparam int PipeLat = LaneLat + 4;

  localparam logic signed [ZW-1:0]    PiQ16      = ZW'(205887);
  localparam logic signed [ZW-1:0]    HalfPiQ16  = ZW'(102944);
  localparam logic signed [XyW-1:0]   CordicInit = XyW'(652032874);
  localparam logic signed [QuatW-1:0] OneQ14     = QuatW'(16384);

  typedef enum logic [OrderW-1:0] {
    ORD_XYZ = 3'd0,
    ORD_XZY = 3'd1,
    ORD_YXZ = 3'd2,
    ORD_YZX = 3'd3,
    ORD_ZXY = 3'd4,
    ORD_ZYX = 3'd5
  } order_t;

  typedef struct packed {
    logic signed [ScW-1:0] s;
    logic signed [ScW-1:0] c;
  } sincos_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0: v = ZW'(51472);
      1: v = ZW'(30386);
      2: v = ZW'(16055);
      3: v = ZW'(8150);
      4: v = ZW'(4091);
      5: v = ZW'(2047);
      6: v = ZW'(1024);
      7: v = ZW'(512);
      8: v = ZW'(256);
      9: v = ZW'(128);
      10: v = ZW'(64);
      11: v = ZW'(32);
      12: v = ZW'(16);
      13: v = ZW'(8);
      14: v = ZW'(4);
      15: v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  // plus/minus per component, bit order {x, y, z, w}, 1 = plus
  function automatic logic [3:0] order_sign(input logic [OrderW-1:0] ord);
    logic [3:0] sg;
    case (ord)
      ORD_XYZ: sg = 4'b1010;
      ORD_XZY: sg = 4'b0011;
      ORD_YXZ: sg = 4'b1001;
      ORD_YZX: sg = 4'b1100;
      ORD_ZXY: sg = 4'b0110;
      ORD_ZYX: sg = 4'b0101;
      default: sg = 4'b0000;
    endcase
    return sg;
  endfunction

  function automatic logic order_valid(input logic [OrderW-1:0] ord);
    return ord inside {ORD_XYZ, ORD_XZY, ORD_YXZ, ORD_YZX, ORD_ZXY, ORD_ZYX};
  endfunction

endpackage

// ===== sv/e2q_if.sv =====
// Handshake channel interfaces for angle beats in and quaternion beats out.
// Depends on e2q_pkg for widths.
interface e2q_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [e2q_pkg::AngleW-1:0]   angle_x;
  logic signed [e2q_pkg::AngleW-1:0]   angle_y;
  logic signed [e2q_pkg::AngleW-1:0]   angle_z;
  logic        [e2q_pkg::OrderW-1:0]   rotation_order;
  modport source (output valid, angle_x, angle_y, angle_z, rotation_order, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, rotation_order, output ready);
endinterface

interface e2q_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [e2q_pkg::QuatW-1:0]   quat_x;
  logic signed [e2q_pkg::QuatW-1:0]   quat_y;
  logic signed [e2q_pkg::QuatW-1:0]   quat_z;
  logic signed [e2q_pkg::QuatW-1:0]   quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== sv/e2q_lane.sv =====
// One half-angle sine/cosine lane: range reduction, 16-stage pipelined CORDIC, rounding.
// Depends on e2q_pkg.
module e2q_lane (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [e2q_pkg::AngleW-1:0] angle,
  output e2q_pkg::sincos_t                  sc
);
  import e2q_pkg::*;

  logic signed [XyW-1:0] x_r [0:Steps];
  logic signed [XyW-1:0] y_r [0:Steps];
  logic signed [ZW-1:0]  z_r [0:Steps];
  logic                  neg_r [0:Steps];
  sincos_t               sc_r;

  logic signed [ZW-1:0]  z_in;
  logic signed [ZW-1:0]  z_nxt;
  logic                  neg_nxt;
  logic signed [XyW-1:0] cx, cy;
  logic signed [XyW-1:0] rc, rs;

  // angle read as Q.13 is the half angle; shift to Q.16
  assign z_in = {angle[AngleW-1], angle, 3'b000};

  always_comb begin
    z_nxt   = z_in;
    neg_nxt = 1'b0;
    if (z_in > HalfPiQ16) begin
      z_nxt   = z_in - PiQ16;
      neg_nxt = 1'b1;
    end else if (z_in < -HalfPiQ16) begin
      z_nxt   = z_in + PiQ16;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]   <= CordicInit;
      y_r[0]   <= '0;
      z_r[0]   <= z_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic signed [ZW-1:0] Atan = atan_q16(i);
    logic signed [XyW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - Atan;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + Atan;
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // undo the pi shift, then round to Q.20
  assign cx = neg_r[Steps] ? -x_r[Steps] : x_r[Steps];
  assign cy = neg_r[Steps] ? -y_r[Steps] : y_r[Steps];
  assign rc = cx + XyW'(512);
  assign rs = cy + XyW'(512);

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_r.c <= rc[XyW-1:10];
      sc_r.s <= rs[XyW-1:10];
    end
  end

  assign sc = sc_r;
endmodule

// ===== sv/e2q_merge.sv =====
// Merge stage: forms the triple products of the three lanes, applies the order signs,
// rounds to Q1.14 and clamps. Four register stages. Depends on e2q_pkg.
module e2q_merge (
  input  logic                              clk,
  input  logic                              adv,
  input  e2q_pkg::sincos_t                  sc1,
  input  e2q_pkg::sincos_t                  sc2,
  input  e2q_pkg::sincos_t                  sc3,
  input  logic        [e2q_pkg::OrderW-1:0] ord,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_x,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_y,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_z,
  output logic signed [e2q_pkg::QuatW-1:0]  quat_w
);
  import e2q_pkg::*;

  localparam int HalfW = PairW / 2;

  // pair index: 0 s1c2, 1 c1s2, 2 c1c2, 3 s1s2; third factor: 0 c3, 1 s3
  logic signed [PairW-1:0]   pair_r [0:3];
  sincos_t                   sc3_r;
  logic signed [TripW-1:0]   hi_r   [0:3][0:1];
  logic signed [HalfW+ScW:0] lo_r   [0:3][0:1];
  logic signed [TripW-1:0]   trip_r [0:3][0:1];
  logic signed [QuatW-1:0]   q_r    [0:3];

  always_ff @(posedge clk) begin
    if (adv) begin
      pair_r[0] <= sc1.s * sc2.c;
      pair_r[1] <= sc1.c * sc2.s;
      pair_r[2] <= sc1.c * sc2.c;
      pair_r[3] <= sc1.s * sc2.s;
      sc3_r     <= sc3;
    end
  end

  // split each pair product into a signed high and unsigned low half
  for (genvar p = 0; p < 4; p++) begin : g_pair
    for (genvar q = 0; q < 2; q++) begin : g_third
      logic signed [ScW-1:0] f;
      logic signed [HalfW-1:0] ph;
      logic signed [HalfW:0]   pl;
      assign f  = (q == 0) ? sc3_r.c : sc3_r.s;
      assign ph = pair_r[p][PairW-1:HalfW];
      assign pl = $signed({1'b0, pair_r[p][HalfW-1:0]});
      always_ff @(posedge clk) begin
        if (adv) begin
          hi_r[p][q] <= TripW'(ph * f);
          lo_r[p][q] <= pl * f;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          trip_r[p][q] <= (hi_r[p][q] <<< HalfW) + TripW'(lo_r[p][q]);
        end
      end
    end
  end

  function automatic logic signed [QuatW-1:0] round_clamp(
    input logic signed [TripW-1:0] a,
    input logic signed [TripW-1:0] b,
    input logic                    plus
  );
    logic signed [TripW:0] v;
    logic signed [TripW-46:0] r;
    logic signed [QuatW-1:0] o;
    v = plus ? ((TripW+1)'(a) + (TripW+1)'(b)) : ((TripW+1)'(a) - (TripW+1)'(b));
    v = v + ((TripW+1)'(1) <<< 45);
    r = v[TripW:46];
    if (r > (TripW-45)'(OneQ14)) begin
      o = OneQ14;
    end else if (r < -(TripW-45)'(OneQ14)) begin
      o = -OneQ14;
    end else begin
      o = r[QuatW-1:0];
    end
    return o;
  endfunction

  logic [3:0] sg;
  assign sg = order_sign(ord);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!order_valid(ord)) begin
        q_r[0] <= '0;
        q_r[1] <= '0;
        q_r[2] <= '0;
        q_r[3] <= OneQ14;
      end else begin
        q_r[0] <= round_clamp(trip_r[0][0], trip_r[1][1], sg[3]);
        q_r[1] <= round_clamp(trip_r[1][0], trip_r[0][1], sg[2]);
        q_r[2] <= round_clamp(trip_r[2][1], trip_r[3][0], sg[1]);
        q_r[3] <= round_clamp(trip_r[2][0], trip_r[3][1], sg[0]);
      end
    end
  end

  assign quat_x = q_r[0];
  assign quat_y = q_r[1];
  assign quat_z = q_r[2];
  assign quat_w = q_r[3];
endmodule

// ===== sv/euler_to_quaternion.sv =====
// Euler angles (Q3.12 radians, six rotation orders) to a unit quaternion in Q1.14.
// Three CORDIC lanes form the half-angle sine and cosine in parallel; a merge stage
// multiplies, signs, rounds and clamps. One beat is accepted every cycle unless the
// pipeline is stalled; it has 16 CORDIC stages, range reduction, rounding and four
// multiply/merge stages. The whole pipeline advances together and holds when the
// output beat is not taken. Order codes 6 and 7 return the identity quaternion.
module euler_to_quaternion (
  input  logic   clk,
  input  logic   rst_n,
  e2q_in_if.sink   in_ch,
  e2q_out_if.source out_ch
);
  import e2q_pkg::*;

  logic                  adv;
  logic [PipeLat-1:0]    valid_r;
  logic [PipeLat-1:0]    valid_nxt;
  logic [OrderW-1:0]     ord_r [0:PipeLat-1];
  sincos_t               sc1, sc2, sc3;

  assign adv          = !valid_r[PipeLat-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = valid_r[PipeLat-1];
  assign valid_nxt    = {valid_r[PipeLat-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ord_r[0] <= in_ch.rotation_order;
      for (int k = 1; k < PipeLat; k++) begin
        ord_r[k] <= ord_r[k-1];
      end
    end
  end

  e2q_lane u_lane_x (.clk(clk), .adv(adv), .angle(in_ch.angle_x), .sc(sc1));
  e2q_lane u_lane_y (.clk(clk), .adv(adv), .angle(in_ch.angle_y), .sc(sc2));
  e2q_lane u_lane_z (.clk(clk), .adv(adv), .angle(in_ch.angle_z), .sc(sc3));

  e2q_merge u_merge (
    .clk    (clk),
    .adv    (adv),
    .sc1    (sc1),
    .sc2    (sc2),
    .sc3    (sc3),
    .ord    (ord_r[PipeLat-2]),
    .quat_x (out_ch.quat_x),
    .quat_y (out_ch.quat_y),
    .quat_z (out_ch.quat_z),
    .quat_w (out_ch.quat_w)
  );

`ifndef SYNTHESIS
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !order_valid(ord_r[PipeLat-1]) |->
      out_ch.quat_x == 0 && out_ch.quat_y == 0 && out_ch.quat_z == 0 &&
      out_ch.quat_w == OneQ14)
    else $error("unused order code did not give identity");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      out_ch.quat_x <= OneQ14 && out_ch.quat_x >= -OneQ14 &&
      out_ch.quat_y <= OneQ14 && out_ch.quat_y >= -OneQ14 &&
      out_ch.quat_z <= OneQ14 && out_ch.quat_z >= -OneQ14 &&
      out_ch.quat_w <= OneQ14 && out_ch.quat_w >= -OneQ14)
    else $error("quaternion component outside clamp range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_r))
    else $error("pipeline moved while stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !in_ch.valid |=> !valid_r[0])
    else $error("bubble not carried into pipeline");
`endif
endmodule

// ===== tb/sv/e2q_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench copy point for the channel interfaces: none needed beyond sv/e2q_if.sv.
// Holds the scoreboard class used by the top; depends on e2q_pkg.
package e2q_tb_pkg;
  import e2q_pkg::*;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_beat_t;

  class quat_scoreboard;
    quat_beat_t pending[$];
    int         errors;

    // half-angle sine and cosine in Q.20
    static function void half_trig(logic signed [15:0] ang, output longint s,
                                   output longint c);
      longint z, x, y, dx, dy;
      longint atab[16];
      bit     flip;
      atab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
               256, 128, 64, 32, 16, 8, 4, 2};
      z = longint'(ang) * 8;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 102944) begin
        z -= 205887;
        flip = 1;
      end else if (z < -102944) begin
        z += 205887;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atab[i];
        end else begin
          x += dx; y -= dy; z += atab[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = (x + 512) >>> 10;
      s = (y + 512) >>> 10;
    endfunction

    static function logic signed [15:0] merge(longint a, longint b, bit plus);
      longint v;
      v = plus ? a + b : a - b;
      v = (v + (longint'(1) << 45)) >>> 46;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
    endfunction

    function void note_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic [2:0] ord);
      longint s1, c1, s2, c2, s3, c3;
      logic [3:0] sg;
      quat_beat_t q;
      if (!(ord inside {ORD_XYZ, ORD_XZY, ORD_YXZ, ORD_YZX, ORD_ZXY, ORD_ZYX})) begin
        q = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
      end else begin
        case (ord)
          ORD_XYZ: sg = 4'b1010;
          ORD_XZY: sg = 4'b0011;
          ORD_YXZ: sg = 4'b1001;
          ORD_YZX: sg = 4'b1100;
          ORD_ZXY: sg = 4'b0110;
          default: sg = 4'b0101;
        endcase
        half_trig(ax, s1, c1);
        half_trig(ay, s2, c2);
        half_trig(az, s3, c3);
        q.qx = merge(s1 * c2 * c3, c1 * s2 * s3, sg[3]);
        q.qy = merge(c1 * s2 * c3, s1 * c2 * s3, sg[2]);
        q.qz = merge(c1 * c2 * s3, s1 * s2 * c3, sg[1]);
        q.qw = merge(c1 * c2 * c3, s1 * s2 * s3, sg[0]);
      end
      pending.push_back(q);
    endfunction

    function void check_quat(quat_beat_t got);
      quat_beat_t exp_q;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat x=%0d y=%0d z=%0d w=%0d",
                   got.qx, got.qy, got.qz, got.qw);
        return;
      end
      exp_q = pending.pop_front();
      if (exp_q != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp x=%0d y=%0d z=%0d w=%0d got x=%0d y=%0d z=%0d w=%0d",
                   exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw,
                   got.qx, got.qy, got.qz, got.qw);
      end
    endfunction
  endclass
endpackage

// ===== tb/sv/tb_euler_to_quaternion.sv =====
`timescale 1ns / 100ps
// Top of the Euler-to-quaternion testbench: drives angle beats, takes quaternion
// beats and checks them. Depends on e2q_pkg, e2q_if, e2q_tb_pkg and the block.
module tb_euler_to_quaternion;
  import e2q_pkg::*;
  import e2q_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  e2q_in_if  in_ch();
  e2q_out_if out_ch();

  euler_to_quaternion uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  quat_scoreboard board = new();
  int  send_idle_pct = 31;
  int  take_idle_pct = 52;
  bit  hold_off = 0;
  bit  stim_done = 0;
  longint cycles = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.angle_x = 0;
    in_ch.angle_y = 0;
    in_ch.angle_z = 0;
    in_ch.rotation_order = 0;
    out_ch.ready = 0;
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      board.check_quat('{out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w});
    if (!rst_n || hold_off)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("euler_to_quaternion verification failed");
      $finish;
    end
  end

  task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic [2:0] ord);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.angle_x <= ax;
    in_ch.angle_y <= ay;
    in_ch.angle_z <= az;
    in_ch.rotation_order <= ord;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_angles(ax, ay, az, ord);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(12868)) - 16'sd6434; // within +/- pi/2 (half angle +/- pi/4)
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_angles(rand_angle(), rand_angle(), rand_angle(),
                  ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                           : 3'($urandom_range(5)));
  endtask

  initial begin
    logic signed [15:0] edges[6];
    edges = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sd12868, -16'sd12868, 16'sd6434};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // every order code, field extremes and the pi boundaries
    for (int o = 0; o < 8; o++)
      send_angles(16'sd3000, -16'sd2000, 16'sd1000, 3'(o));
    for (int k = 0; k < 6; k++)
      send_angles(edges[k], edges[(k + 1) % 6], edges[(k + 2) % 6], 3'(k));
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff, ORD_ZYX);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000, ORD_XYZ);
    send_angles(16'sh5555, 16'shaaaa, 16'sh5555, 3'd7);
    // pause until all expected beats are back
    drain();
    random_phase(480);
    send_idle_pct = 52;
    take_idle_pct = 31;
    random_phase(480);
    send_idle_pct = 0;
    take_idle_pct = 0;
    // hold the output so the pipeline fills and stalls the input
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      random_phase(80);
    join
    random_phase(400);
    drain();
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("euler_to_quaternion verification clean");
    else
      $display("euler_to_quaternion verification failed");
    $finish;
  end
endmodule

// ===== euler_to_quaternion.f =====
sv/e2q_pkg.sv
sv/e2q_if.sv
sv/e2q_lane.sv
sv/e2q_merge.sv
sv/euler_to_quaternion.sv
tb/sv/e2q_tb_if.sv
tb/sv/tb_euler_to_quaternion.sv
